>>> design/segc_pkg.sv
package segc_pkg;

   localparam int MAX_SEGMENTS_DEF = 32;

   // command field codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // classified operations in the work queue
   localparam logic [1:0] OP_NOP   = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_HEADER    = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_TRAILING  = 3'd3;
   localparam logic [2:0] ST_TRUNCATED = 3'd4;

   // register indexes
   localparam logic REG_SEG_COUNT  = 1'b0;
   localparam logic REG_SUM_TARGET = 1'b1;

   localparam int CSR_DATA_W = 16;

   // a segment may end exactly at the top of its bank
   localparam logic [16:0] SEG_LIMIT = 17'h10000;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  entry_index;
      logic [7:0]  seg_bank;
      logic [15:0] seg_address;
      logic [15:0] seg_length;
      logic [15:0] request_bytes;
   } segc_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        copy_valid;
      logic [7:0]  copy_bank;
      logic [15:0] copy_address;
      logic [15:0] copy_length;
      logic [15:0] dest_offset;
      logic        last;
   } segc_rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  entry_index;
      logic [7:0]  seg_bank;
      logic [15:0] seg_address;
      logic [15:0] seg_length;
      logic [15:0] request_bytes;
   } segc_op_type;

   typedef struct packed {
      logic [7:0]  bank;
      logic [15:0] address;
      logic [15:0] length;
   } segc_seg_type;

endpackage

>>> design/segc_req_if.sv
interface segc_req_if;
   logic                    valid;
   logic                    ready;
   segc_pkg::segc_req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/segc_rsp_if.sv
interface segc_rsp_if;
   logic                    valid;
   logic                    ready;
   segc_pkg::segc_rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/segc_ram.sv
module segc_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> design/segc_front.sv
module segc_front #(
   parameter int MAX_SEGMENTS = segc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   segc_req_if.sink             req_ch,
   output logic                 q_valid,
   output segc_pkg::segc_op_type q_head,
   input  logic                 q_pop
);
   localparam logic [1:0] DEPTH = 2'd2;

   segc_pkg::segc_op_type slots_ff [2];
   logic [1:0]            count_ff, count_in;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic                  accept;
   segc_pkg::segc_op_type classified;

   assign req_ch.ready = (count_ff != DEPTH);
   assign accept       = req_ch.valid && req_ch.ready;

   // sort the beat into an operation; out-of-range loads and unknown commands become no-ops
   always_comb begin
      classified.entry_index   = req_ch.payload.entry_index;
      classified.seg_bank      = req_ch.payload.seg_bank;
      classified.seg_address   = req_ch.payload.seg_address;
      classified.seg_length    = req_ch.payload.seg_length;
      classified.request_bytes = req_ch.payload.request_bytes;
      case (req_ch.payload.command)
         segc_pkg::CMD_LOAD: begin
            if (32'(req_ch.payload.entry_index) < MAX_SEGMENTS) begin
               classified.op = segc_pkg::OP_LOAD;
            end else begin
               classified.op = segc_pkg::OP_NOP;
            end
         end
         segc_pkg::CMD_START: classified.op = segc_pkg::OP_START;
         segc_pkg::CMD_READ:  classified.op = segc_pkg::OP_READ;
         default:             classified.op = segc_pkg::OP_NOP;
      endcase
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_head  = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, accept} - {1'b0, q_pop};
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slots_ff[wr_ptr_ff] <= classified;
      end
   end
endmodule

>>> design/segc_back.sv
module segc_back #(
   parameter int MAX_SEGMENTS = segc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  segc_pkg::segc_op_type q_head,
   output logic                  q_pop,
   input  logic [5:0]            seg_count,
   input  logic [15:0]           sum_target,
   segc_rsp_if.source            rsp_ch
);
   localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CUR_W = $clog2(MAX_SEGMENTS + 1);
   localparam int SUM_W = 16 + CUR_W;
   localparam logic [6:0] MAX_V = 7'(MAX_SEGMENTS);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_START_RD  = 3'd1;
   localparam logic [2:0] S_START_CHK = 3'd2;
   localparam logic [2:0] S_READ_CHK  = 3'd3;
   localparam logic [2:0] S_READ_STEP = 3'd4;
   localparam logic [2:0] S_FINISH    = 3'd5;

   typedef struct packed {
      logic [7:0]  bank;
      logic [15:0] address;
      logic [15:0] length;
      logic [15:0] dest;
   } segc_chunk_type;

   logic [2:0]             state_ff, state_in;
   logic                   started_ff, started_in;
   logic [CUR_W-1:0]       active_ff, active_in;
   logic [CUR_W-1:0]       cursor_idx_ff, cursor_idx_in;
   logic [15:0]            cursor_off_ff, cursor_off_in;
   logic [15:0]            remain_ff, remain_in;
   logic [CUR_W-1:0]       start_i_ff, start_i_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [15:0]            req_left_ff, req_left_in;
   logic [15:0]            done_ff, done_in;
   logic                   pend_valid_ff, pend_valid_in;
   segc_chunk_type         pend_ff, pend_in;
   logic [2:0]             fin_status_ff, fin_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   segc_pkg::segc_rsp_type rsp_data_ff, rsp_data_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [39:0]            ram_rdata;
   segc_pkg::segc_seg_type seg;
   segc_pkg::segc_seg_type wr_seg;

   logic                   out_free;
   logic [16:0]            seg_end;
   logic [CUR_W-1:0]       start_next;
   logic [15:0]            avail, chunk, new_off;

   assign wr_seg.bank    = q_head.seg_bank;
   assign wr_seg.address = q_head.seg_address;
   assign wr_seg.length  = q_head.seg_length;
   assign ram_waddr      = AW'(q_head.entry_index);
   assign ram_raddr      = (state_ff == S_START_RD || state_ff == S_START_CHK)
                           ? start_i_ff[AW-1:0] : cursor_idx_ff[AW-1:0];

   segc_ram #(
      .WIDTH (40),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_seg),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign seg        = segc_pkg::segc_seg_type'(ram_rdata);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign seg_end    = {1'b0, seg.address} + {1'b0, seg.length};
   assign start_next = start_i_ff + CUR_W'(1);
   assign avail      = seg.length - cursor_off_ff;
   assign chunk      = (req_left_ff < avail) ? req_left_ff : avail;
   assign new_off    = cursor_off_ff + chunk;

   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      active_in     = active_ff;
      cursor_idx_in = cursor_idx_ff;
      cursor_off_in = cursor_off_ff;
      remain_in     = remain_ff;
      start_i_in    = start_i_ff;
      sum_in        = sum_ff;
      req_left_in   = req_left_ff;
      done_in       = done_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      fin_status_in = fin_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = S_FINISH;
               fin_status_in = segc_pkg::ST_OK;
               case (q_head.op)
                  segc_pkg::OP_LOAD: begin
                     ram_we = 1'b1;
                  end
                  segc_pkg::OP_START: begin
                     if (seg_count == 6'd0 || sum_target == 16'd0 ||
                         {1'b0, seg_count} > MAX_V) begin
                        fin_status_in = segc_pkg::ST_HEADER;
                     end else begin
                        start_i_in = '0;
                        sum_in     = '0;
                        state_in   = S_START_RD;
                     end
                  end
                  segc_pkg::OP_READ: begin
                     if (!started_ff) begin
                        fin_status_in = segc_pkg::ST_HEADER;
                     end else if (q_head.request_bytes > remain_ff) begin
                        fin_status_in = segc_pkg::ST_OVERFLOW;
                     end else begin
                        req_left_in = q_head.request_bytes;
                        done_in     = 16'd0;
                        state_in    = S_READ_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START_RD: begin
            state_in = S_START_CHK;
         end
         S_START_CHK: begin
            state_in = S_FINISH;
            if (seg.length == 16'd0 || seg_end > segc_pkg::SEG_LIMIT) begin
               fin_status_in = segc_pkg::ST_OVERFLOW;
            end else begin
               sum_in = sum_ff + SUM_W'(seg.length);
               if (start_next == CUR_W'(seg_count)) begin
                  if (sum_in != SUM_W'(sum_target)) begin
                     fin_status_in = segc_pkg::ST_TRAILING;
                  end else begin
                     fin_status_in = segc_pkg::ST_OK;
                     active_in     = CUR_W'(seg_count);
                     cursor_idx_in = '0;
                     cursor_off_in = 16'd0;
                     remain_in     = sum_target;
                     started_in    = 1'b1;
                  end
               end else begin
                  start_i_in = start_next;
                  state_in   = S_START_RD;
               end
            end
         end
         S_READ_CHK: begin
            if (req_left_ff == 16'd0) begin
               fin_status_in = segc_pkg::ST_OK;
               state_in      = S_FINISH;
            end else if (cursor_idx_ff >= active_ff) begin
               fin_status_in = segc_pkg::ST_TRUNCATED;
               state_in      = S_FINISH;
            end else begin
               state_in = S_READ_STEP;
            end
         end
         S_READ_STEP: begin
            // the held chunk goes out only once we know it is not the last
            if (!(chunk != 16'd0 && pend_valid_ff && !out_free)) begin
               if (chunk != 16'd0) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.status       = segc_pkg::ST_OK;
                     rsp_data_in.copy_valid   = 1'b1;
                     rsp_data_in.copy_bank    = pend_ff.bank;
                     rsp_data_in.copy_address = pend_ff.address;
                     rsp_data_in.copy_length  = pend_ff.length;
                     rsp_data_in.dest_offset  = pend_ff.dest;
                     rsp_data_in.last         = 1'b0;
                  end
                  pend_valid_in   = 1'b1;
                  pend_in.bank    = seg.bank;
                  pend_in.address = seg.address + cursor_off_ff;
                  pend_in.length  = chunk;
                  pend_in.dest    = done_ff;
               end
               done_in     = done_ff + chunk;
               req_left_in = req_left_ff - chunk;
               remain_in   = remain_ff - chunk;
               if (new_off == seg.length) begin
                  cursor_idx_in = cursor_idx_ff + CUR_W'(1);
                  cursor_off_in = 16'd0;
               end else begin
                  cursor_off_in = new_off;
               end
               state_in = S_READ_CHK;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = fin_status_ff;
               rsp_data_in.last   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in.copy_valid   = 1'b1;
                  rsp_data_in.copy_bank    = pend_ff.bank;
                  rsp_data_in.copy_address = pend_ff.address;
                  rsp_data_in.copy_length  = pend_ff.length;
                  rsp_data_in.dest_offset  = pend_ff.dest;
               end else begin
                  rsp_data_in.copy_valid   = 1'b0;
                  rsp_data_in.copy_bank    = 8'd0;
                  rsp_data_in.copy_address = 16'd0;
                  rsp_data_in.copy_length  = 16'd0;
                  rsp_data_in.dest_offset  = 16'd0;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         started_ff    <= 1'b0;
         active_ff     <= '0;
         cursor_idx_ff <= '0;
         cursor_off_ff <= 16'd0;
         remain_ff     <= 16'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         active_ff     <= active_in;
         cursor_idx_ff <= cursor_idx_in;
         cursor_off_ff <= cursor_off_in;
         remain_ff     <= remain_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_i_ff    <= start_i_in;
      sum_ff        <= sum_in;
      req_left_ff   <= req_left_in;
      done_ff       <= done_in;
      pend_ff       <= pend_in;
      fin_status_ff <= fin_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // no chunk may be left behind once an item is closed out
   a_no_pend_in_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("held chunk left over after item end");

   // only the final beat of an item may carry a status or lack a copy
   a_mid_beat_is_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last |->
         rsp_data_ff.copy_valid && rsp_data_ff.status == segc_pkg::ST_OK)
      else $error("non-final beat without copy or with status");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> cursor_idx_ff <= active_ff)
      else $error("cursor past active segment count");

   a_read_needs_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ_STEP |-> started_ff)
      else $error("read walk without a successful start");
endmodule

>>> design/segment_gather_cursor.sv
// Channel   | Direction | Handshake       | Beat contents
// ----------+-----------+-----------------+----------------------------------------
// req_ch    | in        | valid/ready     | command, entry, segment, request bytes
// rsp_ch    | out       | valid/ready     | status, copy command, dest offset, last
// csr_*     | in        | write enable    | seg count (0), byte total (1)
//
// Starts and reads walk the table one segment at a time, waiting on the table RAM's
// registered read port at each segment visited.
// Items run one at a time; the 2-entry queue keeps intake open meanwhile.
// Reset: synchronous, active high; clears cursor, start flag, config and queue, not table.
// Stalls: rsp ready low holds the executor only once it has another beat to hand over.
module segment_gather_cursor #(
   parameter int MAX_SEGMENTS = segc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   segc_req_if.sink                         req_ch,
   segc_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [segc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   // configuration registers; the user must write them only while the block is idle, the block does not enforce it
   logic [5:0]  seg_count_ff, seg_count_in;
   logic [15:0] total_ff, total_in;

   // classified operation crossing from intake to executor
   logic                  q_valid;
   logic                  q_pop;
   segc_pkg::segc_op_type q_head;

   always_comb begin
      seg_count_in = seg_count_ff;
      total_in     = total_ff;
      if (csr_we) begin
         case (csr_index)
            segc_pkg::REG_SEG_COUNT:  seg_count_in = csr_wdata[5:0];
            segc_pkg::REG_SUM_TARGET: total_in     = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= 6'd0;
         total_ff     <= 16'd0;
      end else begin
         seg_count_ff <= seg_count_in;
         total_ff     <= total_in;
      end
   end

   // intake: accepts beats, classifies, queues
   segc_front #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // executor: table, cursor walk, result beats
   segc_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .seg_count  (seg_count_ff),
      .sum_target (total_ff),
      .rsp_ch     (rsp_ch)
   );
endmodule

>>> bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import segc_pkg::*;

   localparam int SEG_SLOTS = MAX_SEGMENTS_DEF;
   // command 3 has no meaning; the block answers it with a plain ok
   localparam logic [1:0] CMD_NONE = 2'd3;
   // long enough for a start over a full table to walk all 32 entries, plus overhead
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_BEATS = 170;

   typedef enum logic [1:0] {ROW_CFG, ROW_TYPED, ROW_MODEL} row_kind_type;
   typedef enum logic [1:0] {PH_PLAIN, PH_WIDE, PH_HUGE, PH_BADHDR} phase_type;

   // config rows: bank column = segment count, len column = byte total
   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   cmd;
      logic [4:0]   idx;
      logic [7:0]   bank;
      logic [15:0]  addr;
      logic [15:0]  len;
      logic [15:0]  nbytes;
      logic [2:0]   st;
   } plan_row_type;

   // Directed walk. Table entries 0 and 1 form a two segment list; entry 0 ends
   // exactly at the top of its bank and entry 1 starts at address 0.
   localparam plan_row_type DIR_PLAN [26] = '{
      // nothing started yet, config still at reset
      '{ROW_TYPED, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'hFFFF, ST_HEADER},
      '{ROW_TYPED, CMD_START, 5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_HEADER},
      '{ROW_TYPED, CMD_NONE,  5'd31, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, ST_OK},
      '{ROW_CFG,   CMD_NONE,  5'd0,  8'd2,  16'h0000, 16'h0030, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_LOAD,  5'd0,  8'hFF, 16'hFFF0, 16'h0010, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_LOAD,  5'd1,  8'h00, 16'h0000, 16'h0020, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_LOAD,  5'd31, 8'hAA, 16'h5555, 16'hFFFF, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0001, ST_HEADER},
      '{ROW_TYPED, CMD_START, 5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_OK},
      // empty read, then a read one byte too long
      '{ROW_TYPED, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0031, ST_OVERFLOW},
      // a read that splits across the segment boundary, a read to the end, then one past the end
      '{ROW_MODEL, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0018, ST_OK},
      '{ROW_MODEL, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0018, ST_OK},
      '{ROW_TYPED, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0001, ST_OVERFLOW},
      // restart, then shrink segment 1 under the cursor: truncation on a chunk,
      // then truncation with no chunk at all
      '{ROW_TYPED, CMD_START, 5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_LOAD,  5'd1,  8'h00, 16'h0000, 16'h0010, 16'h0000, ST_OK},
      '{ROW_MODEL, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0030, ST_OK},
      '{ROW_MODEL, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0010, ST_OK},
      // start checks: wrong sum, segment past the bank top
      '{ROW_TYPED, CMD_START, 5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_TRAILING},
      '{ROW_TYPED, CMD_LOAD,  5'd1,  8'h00, 16'hFFF8, 16'h0020, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_START, 5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_OVERFLOW},
      '{ROW_TYPED, CMD_LOAD,  5'd1,  8'h00, 16'h0000, 16'h0020, 16'h0000, ST_OK},
      '{ROW_TYPED, CMD_START, 5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_OK},
      // empty segment after start: zero length chunk is skipped, cursor moves on
      '{ROW_TYPED, CMD_LOAD,  5'd0,  8'hFF, 16'hFFF0, 16'h0000, 16'h0000, ST_OK},
      '{ROW_MODEL, CMD_READ,  5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0008, ST_OK},
      '{ROW_TYPED, CMD_START, 5'd0,  8'h00, 16'h0000, 16'h0000, 16'h0000, ST_OVERFLOW}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   segc_req_if req_ch ();
   segc_rsp_if rsp_ch ();

   segment_gather_cursor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   // ------------------------------------------------------------------
   // Gather predictor: own copy of the table, cursor and config
   // ------------------------------------------------------------------
   segc_seg_type seg_tab [SEG_SLOTS];
   logic [5:0]   cfg_count;
   logic [15:0]  cfg_total;
   int unsigned  cur_idx;
   int unsigned  active_segs;
   logic [15:0]  cur_off;
   logic [15:0]  owed_bytes;
   bit           started;

   segc_rsp_type beat_out[$];      // results of the beat just predicted
   segc_rsp_type pending_rsp[$];   // results owed by the block, oldest first

   int  errors;
   int  rsp_seen;
   int  random_beats;
   bit  tx_quiet;
   bit  rx_quiet;

   function automatic segc_rsp_type status_only(logic [2:0] st);
      segc_rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   // start: header checks, then per-segment checks, then the sum
   function automatic logic [2:0] validate_table();
      int unsigned n;
      int unsigned sum;
      n = cfg_count;
      sum = 0;
      if (n == 0 || cfg_total == 0 || n > SEG_SLOTS)
         return ST_HEADER;
      for (int unsigned i = 0; i < n; i++) begin
         if (seg_tab[i].length == 0 ||
             int'(seg_tab[i].address) + int'(seg_tab[i].length) > int'(SEG_LIMIT))
            return ST_OVERFLOW;
         sum += seg_tab[i].length;
      end
      if (sum != cfg_total)
         return ST_TRAILING;
      active_segs = n;
      cur_idx = 0;
      cur_off = '0;
      owed_bytes = cfg_total;
      started = 1'b1;
      return ST_OK;
   endfunction

   task automatic split_read(logic [15:0] want);
      segc_rsp_type r;
      segc_seg_type s;
      logic [15:0]  avail;
      logic [15:0]  chunk;
      logic [15:0]  done;
      done = '0;
      if (!started) begin
         beat_out.push_back(status_only(ST_HEADER));
         return;
      end
      if (want > owed_bytes) begin
         beat_out.push_back(status_only(ST_OVERFLOW));
         return;
      end
      while (want != 0) begin
         if (cur_idx >= active_segs || cur_idx >= SEG_SLOTS) begin
            // ran off the active list with bytes still owed
            if (beat_out.size() > 0) begin
               r = beat_out.pop_back();
               r.status = ST_TRUNCATED;
               r.last = 1'b1;
               beat_out.push_back(r);
            end else begin
               beat_out.push_back(status_only(ST_TRUNCATED));
            end
            return;
         end
         s = seg_tab[cur_idx];
         avail = s.length - cur_off;
         chunk = (want < avail) ? want : avail;
         if (chunk != 0 && beat_out.size() < SEG_SLOTS) begin
            r = '0;
            r.copy_valid = 1'b1;
            r.copy_bank = s.bank;
            r.copy_address = s.address + cur_off;
            r.copy_length = chunk;
            r.dest_offset = done;
            beat_out.push_back(r);
         end
         done += chunk;
         want -= chunk;
         owed_bytes -= chunk;
         cur_off += chunk;
         if (cur_off == s.length) begin
            cur_idx++;
            cur_off = '0;
         end
      end
      if (beat_out.size() > 0) begin
         r = beat_out.pop_back();
         r.last = 1'b1;
         beat_out.push_back(r);
      end else begin
         beat_out.push_back(status_only(ST_OK));
      end
   endtask

   task automatic predict_beat(segc_req_type b);
      beat_out.delete();
      case (b.command)
         CMD_LOAD: begin
            seg_tab[b.entry_index] = '{b.seg_bank, b.seg_address, b.seg_length};
            beat_out.push_back(status_only(ST_OK));
         end
         CMD_START: beat_out.push_back(status_only(validate_table()));
         CMD_READ:  split_read(b.request_bytes);
         default:   beat_out.push_back(status_only(ST_OK));
      endcase
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic flag_mismatch(string msg);
      $display("MISMATCH %s", msg);
      errors++;
   endtask

   task automatic cmp_field(string name, int unsigned got, int unsigned exp);
      if (got != exp)
         flag_mismatch($sformatf("result beat %0d %s: got 0x%0h, expected 0x%0h",
                                 rsp_seen, name, got, exp));
   endtask

   // results sampled at the rising edge, before the block updates them
   always @(posedge clock) begin
      segc_rsp_type want;
      segc_rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("result beat %0d arrived with nothing owed", rsp_seen));
         end else begin
            want = pending_rsp.pop_front();
            cmp_field("status",       got.status,       want.status);
            cmp_field("copy_valid",   got.copy_valid,   want.copy_valid);
            cmp_field("copy_bank",    got.copy_bank,    want.copy_bank);
            cmp_field("copy_address", got.copy_address, want.copy_address);
            cmp_field("copy_length",  got.copy_length,  want.copy_length);
            cmp_field("dest_offset",  got.dest_offset,  want.dest_offset);
            cmp_field("last",         got.last,         want.last);
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Idling on both sides: mostly none or short, now and then long
   // ------------------------------------------------------------------
   function automatic int pick_gap(bit quiet);
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side: after each taken beat, hold ready low for a random stall
   initial begin
      int stall;
      bit took;
      rsp_ch.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         took = rsp_ch.valid && rsp_ch.ready;
         @(negedge clock);
         if (took)
            stall = pick_gap(rx_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side. Every task is entered and left at a falling edge.
   // ------------------------------------------------------------------
   task automatic send_beat(segc_req_type b, bit typed, logic [2:0] st);
      int gap;
      gap = pick_gap(tx_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      // beat taken: predict now, so the table and cursor track the block
      predict_beat(b);
      if (typed)
         pending_rsp.push_back(status_only(st));
      else
         foreach (beat_out[k]) pending_rsp.push_back(beat_out[k]);
      @(negedge clock);
   endtask

   // stop sending until every owed result is in, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // only called with the block idle
   task automatic write_cfg(logic [5:0] n, logic [15:0] tot);
      csr_we <= 1'b1;
      csr_index <= REG_SEG_COUNT;
      csr_wdata <= CSR_DATA_W'(n);
      @(negedge clock);
      csr_index <= REG_SUM_TARGET;
      csr_wdata <= tot;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_count = n;
      cfg_total = tot;
   endtask

   // every field random; callers override what matters for the command
   function automatic segc_req_type rand_beat(logic [1:0] cmd);
      segc_req_type b;
      b.command = cmd;
      b.entry_index = 5'($urandom);
      b.seg_bank = 8'($urandom);
      b.seg_address = 16'($urandom);
      b.seg_length = 16'($urandom);
      b.request_bytes = 16'($urandom);
      return b;
   endfunction

   task automatic send_random(segc_req_type b);
      send_beat(b, 1'b0, ST_OK);
      if (b.command != CMD_NONE)
         random_beats++;
   endtask

   // mostly reads sized against the bytes still owed; some noise that
   // disturbs the table or restarts the cursor
   function automatic segc_req_type next_beat();
      segc_req_type b;
      int unsigned r;
      int unsigned p;
      int unsigned cap;
      r = $urandom_range(0, 99);
      if (r < 8)
         return rand_beat(CMD_NONE);
      if (r < 14) begin
         b = rand_beat(CMD_LOAD);
         if ($urandom_range(0, 2) == 0)
            b.seg_length = '0;
         return b;
      end
      if (r < 20)
         return rand_beat(CMD_START);
      b = rand_beat(CMD_READ);
      p = $urandom_range(0, 99);
      cap = (owed_bytes > 48) ? 48 : owed_bytes;
      if (p < 8)
         b.request_bytes = '0;
      else if (p < 18)
         b.request_bytes = (owed_bytes == 16'hFFFF) ? 16'hFFFF :
                           16'($urandom_range(int'(owed_bytes) + 1, 65535));
      else if (p < 30)
         b.request_bytes = owed_bytes;
      else if (p < 65)
         b.request_bytes = 16'($urandom_range(1, cap));
      else
         b.request_bytes = 16'($urandom_range(0, owed_bytes));
      return b;
   endfunction

   // one setting of the registers: fresh table and start (or a bad-header start alone), then reads and noise
   task automatic run_phase(phase_type kind);
      int          n;
      int unsigned sum;
      int unsigned lens [SEG_SLOTS];
      int          steps;
      segc_req_type b;
      drain();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (kind == PH_BADHDR) begin
         // count beyond the table or a zero total: every start fails early
         if ($urandom_range(0, 1))
            write_cfg(6'($urandom_range(33, 63)), 16'($urandom));
         else
            write_cfg(6'($urandom_range(0, 32)), 16'd0);
         b = rand_beat(CMD_START);
         send_random(b);
      end else begin
         n = (kind == PH_WIDE) ? SEG_SLOTS : (kind == PH_HUGE) ? 1 : $urandom_range(1, 6);
         sum = 0;
         for (int i = 0; i < n; i++) begin
            if (kind == PH_WIDE)
               lens[i] = $urandom_range(1, 2047);
            else if (kind == PH_HUGE)
               lens[i] = 65535;
            else if ($urandom_range(0, 4) == 0)
               lens[i] = $urandom_range(1, 4000);
            else
               lens[i] = $urandom_range(1, 64);
            sum += lens[i];
         end
         write_cfg(6'(n), 16'(sum));
         for (int i = 0; i < n; i++) begin
            b = rand_beat(CMD_LOAD);
            b.entry_index = 5'(i);
            b.seg_length = 16'(lens[i]);
            // anywhere in the bank, up to ending exactly at its top
            b.seg_address = 16'($urandom_range(0, 65536 - lens[i]));
            send_random(b);
         end
         send_random(rand_beat(CMD_START));
      end
      steps = $urandom_range(4, 12);
      repeat (steps) send_random(next_beat());
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      plan_row_type row;
      segc_req_type b;
      phase_type    kind;
      int           phase_no;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_we = 1'b0;
      csr_index = REG_SEG_COUNT;
      csr_wdata = '0;
      errors = 0;
      rsp_seen = 0;
      random_beats = 0;
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      cfg_count = '0;
      cfg_total = '0;
      cur_idx = 0;
      active_segs = 0;
      cur_off = '0;
      owed_bytes = '0;
      started = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIR_PLAN); i++) begin
         row = DIR_PLAN[i];
         if (row.kind == ROW_CFG) begin
            drain();
            write_cfg(row.bank[5:0], row.len);
         end else begin
            b = '0;
            b.command = row.cmd;
            b.entry_index = row.idx;
            b.seg_bank = row.bank;
            b.seg_address = row.addr;
            b.seg_length = row.len;
            b.request_bytes = row.nbytes;
            send_beat(b, row.kind == ROW_TYPED, row.st);
         end
      end

      // extremes first (full table, one 65535-byte segment, bad header), then a mix
      phase_no = 0;
      while (random_beats < RANDOM_BEATS) begin
         case (phase_no)
            0: kind = PH_WIDE;
            1: kind = PH_HUGE;
            2: kind = PH_BADHDR;
            default: begin
               case ($urandom_range(0, 9))
                  0: kind = PH_WIDE;
                  1: kind = PH_HUGE;
                  2: kind = PH_BADHDR;
                  default: kind = PH_PLAIN;
               endcase
            end
         endcase
         run_phase(kind);
         phase_no++;
      end

      drain();
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hung handshake guard
   initial begin
      #15ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
